/* design/qlig_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the quadtree LOD index generator.
// No dependencies; used by qlig_addr and quadtree_lod_index_generator_core.

package qlig_pkg;

   // Default geometry
   localparam int DEFAULT_MAX_LOD    = 6;
   localparam int DEFAULT_TILE_WIDTH = 64;

   // Field widths
   localparam int INDEX_W = 32;
   localparam int QC_BITS = 12;
   localparam int LOD_W   = 4;
   localparam int DIGITS  = QC_BITS / 2;

   // Register file
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEVEL_OF_DETAIL = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROOT_START      = 1'd1;

   // Four corner indices of one quad
   typedef struct packed {
      logic [INDEX_W-1:0] tl;
      logic [INDEX_W-1:0] bl;
      logic [INDEX_W-1:0] br;
      logic [INDEX_W-1:0] tr;
   } quad_corners_type;

   // Quad position handed to the address stage
   typedef struct packed {
      logic [QC_BITS-1:0] quad;
      logic [LOD_W-1:0]   level;
      logic [INDEX_W-1:0] root;
   } quad_pos_type;

endpackage

/* design/qlig_addr.sv */
`timescale 1ns / 1ps
// Corner index decode: quad number, level and root vertex to four corner indices.
// Depends on qlig_pkg.

module qlig_addr #(
   parameter int MAX_LOD    = qlig_pkg::DEFAULT_MAX_LOD,
   parameter int TILE_WIDTH = qlig_pkg::DEFAULT_TILE_WIDTH
) (
   input  qlig_pkg::quad_pos_type     pos,
   output qlig_pkg::quad_corners_type corners
);

   localparam int POS_W = MAX_LOD;
   localparam logic [qlig_pkg::INDEX_W-1:0] STRIDE = qlig_pkg::INDEX_W'(TILE_WIDTH + 1);

   logic [qlig_pkg::DIGITS-1:0]   row_bits;
   logic [qlig_pkg::DIGITS-1:0]   col_bits;
   logic [qlig_pkg::LOD_W-1:0]    span_shift;
   logic [POS_W-1:0]              pos_y;
   logic [POS_W-1:0]              pos_x;
   logic [qlig_pkg::INDEX_W-1:0]  quad_side;
   logic [qlig_pkg::INDEX_W-1:0]  step_down;
   logic [qlig_pkg::INDEX_W-1:0]  step_diag;
   logic [qlig_pkg::INDEX_W-1:0]  local_ofs;
   logic [qlig_pkg::INDEX_W-1:0]  tl;

   // Split each base-4 digit into a row and a column step:
   // top-left 0, bottom-left 1, bottom-right 2, top-right 3
   always_comb begin
      for (int j = 0; j < qlig_pkg::DIGITS; j++) begin
         row_bits[j] = pos.quad[2*j] ^ pos.quad[2*j+1];
         col_bits[j] = pos.quad[2*j+1];
      end
   end

   // Scale digit positions by the quad size of the level
   assign span_shift = qlig_pkg::LOD_W'(MAX_LOD) - pos.level;
   assign pos_y = POS_W'({{POS_W{1'b0}}, row_bits} << span_shift);
   assign pos_x = POS_W'({{POS_W{1'b0}}, col_bits} << span_shift);

   // Corner steps of one quad, independent of its position
   assign quad_side = qlig_pkg::INDEX_W'(1) << span_shift;
   assign step_down = STRIDE << span_shift;
   assign step_diag = step_down + quad_side;

   // Row-major vertex offset of the top-left corner
   assign local_ofs = STRIDE * qlig_pkg::INDEX_W'(pos_y) + qlig_pkg::INDEX_W'(pos_x);
   assign tl        = pos.root + local_ofs;

   assign corners.tl = tl;
   assign corners.bl = tl + step_down;
   assign corners.br = tl + step_diag;
   assign corners.tr = tl + quad_side;

endmodule

/* design/quadtree_lod_index_generator_core.sv */
`timescale 1ns / 1ps
// Quadtree terrain LOD index generator, top level.
// Depends on qlig_pkg and qlig_addr.

// One transfer on the request channel yields one quad on the response channel:
// six vertex indices for the triangles TL,BL,BR and TL,BR,TR, the quad number in
// depth-first order (children top-left, bottom-left, bottom-right, top-right) and
// a flag on the level's final quad, after which the walk wraps to quad 0. A request
// with restart set begins again at quad 0. The block takes one request per clock
// cycle when the response side does not stall: the quad counter stage registers
// the quad number, then the corner decode stage (one constant multiply and six
// adds) fills the result register. Write level_of_detail and root_start only
// while no request is in flight; levels above MAX_LOD act as MAX_LOD.

module quadtree_lod_index_generator_core #(
   parameter int MAX_LOD    = qlig_pkg::DEFAULT_MAX_LOD,
   parameter int TILE_WIDTH = qlig_pkg::DEFAULT_TILE_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   // Register write port
   input  logic                                csr_write_enable,
   input  logic [qlig_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [qlig_pkg::CSR_DATA_W-1:0]     csr_write_data,
   // Request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_restart,
   // Response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [qlig_pkg::INDEX_W-1:0]        rsp_index_tl_a,
   output logic [qlig_pkg::INDEX_W-1:0]        rsp_index_bl,
   output logic [qlig_pkg::INDEX_W-1:0]        rsp_index_br_a,
   output logic [qlig_pkg::INDEX_W-1:0]        rsp_index_tl_b,
   output logic [qlig_pkg::INDEX_W-1:0]        rsp_index_br_b,
   output logic [qlig_pkg::INDEX_W-1:0]        rsp_index_tr,
   output logic [qlig_pkg::QC_BITS-1:0]        rsp_quad_number,
   output logic                                rsp_last_of_level
);

   localparam int FULL_LEVEL = qlig_pkg::QC_BITS / 2;

   // Configuration
   logic [qlig_pkg::LOD_W-1:0]   lod_ff;
   logic [qlig_pkg::INDEX_W-1:0] root_ff;
   logic [qlig_pkg::LOD_W-1:0]   eff_level;
   logic [qlig_pkg::QC_BITS-1:0] last_quad;

   // Counter stage
   logic [qlig_pkg::QC_BITS-1:0] count_ff;
   logic [qlig_pkg::QC_BITS-1:0] count_in;
   logic [qlig_pkg::QC_BITS-1:0] quad_sel;
   logic                         quad_is_last;
   logic                         req_xfer;
   logic                         s1_valid_ff;
   logic                         s1_valid_in;
   logic [qlig_pkg::QC_BITS-1:0] s1_quad_ff;
   logic                         s1_last_ff;
   logic                         s1_move;

   // Result stage
   qlig_pkg::quad_pos_type       s1_pos;
   qlig_pkg::quad_corners_type   corners;
   qlig_pkg::quad_corners_type   out_corners_ff;
   logic [qlig_pkg::QC_BITS-1:0] out_quad_ff;
   logic                         out_last_ff;
   logic                         out_valid_ff;
   logic                         out_valid_in;
   logic                         rsp_xfer;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         lod_ff  <= '0;
         root_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            qlig_pkg::CSR_LEVEL_OF_DETAIL: lod_ff  <= csr_write_data[qlig_pkg::LOD_W-1:0];
            qlig_pkg::CSR_ROOT_START:      root_ff <= csr_write_data[qlig_pkg::INDEX_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp the level and find its final quad
   always_comb begin
      if (lod_ff > qlig_pkg::LOD_W'(MAX_LOD)) begin
         eff_level = qlig_pkg::LOD_W'(MAX_LOD);
      end else begin
         eff_level = lod_ff;
      end
      if (eff_level >= qlig_pkg::LOD_W'(FULL_LEVEL)) begin
         last_quad = '1;
      end else begin
         last_quad = (qlig_pkg::QC_BITS'(1) << {eff_level, 1'b0}) - qlig_pkg::QC_BITS'(1);
      end
   end

   // Handshakes
   assign rsp_xfer  = out_valid_ff && !rsp_stall;
   assign s1_move   = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_move;
   assign req_xfer  = req_valid && !req_stall;

   // Pick the quad for this request and advance the walk
   always_comb begin
      if (req_restart || count_ff > last_quad) begin
         quad_sel = '0;
      end else begin
         quad_sel = count_ff;
      end
      quad_is_last = (quad_sel == last_quad);
      if (quad_is_last) begin
         count_in = '0;
      end else begin
         count_in = quad_sel + qlig_pkg::QC_BITS'(1);
      end
      s1_valid_in  = req_xfer || (s1_valid_ff && !s1_move);
      out_valid_in = s1_move || (out_valid_ff && !rsp_xfer);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_xfer) begin
            count_ff <= count_in;
         end
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Hold the selected quad for the decode stage
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_quad_ff <= quad_sel;
         s1_last_ff <= quad_is_last;
      end
   end

   // Decode corner indices
   assign s1_pos.quad  = s1_quad_ff;
   assign s1_pos.level = eff_level;
   assign s1_pos.root  = root_ff;

   qlig_addr #(
      .MAX_LOD    (MAX_LOD),
      .TILE_WIDTH (TILE_WIDTH)
   ) u_addr (
      .pos     (s1_pos),
      .corners (corners)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (s1_move) begin
         out_corners_ff <= corners;
         out_quad_ff    <= s1_quad_ff;
         out_last_ff    <= s1_last_ff;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_index_tl_a    = out_corners_ff.tl;
   assign rsp_index_bl      = out_corners_ff.bl;
   assign rsp_index_br_a    = out_corners_ff.br;
   assign rsp_index_tl_b    = out_corners_ff.tl;
   assign rsp_index_br_b    = out_corners_ff.br;
   assign rsp_index_tr      = out_corners_ff.tr;
   assign rsp_quad_number   = out_quad_ff;
   assign rsp_last_of_level = out_last_ff;

   // A restart always begins the walk at quad 0
   assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_restart |=> s1_quad_ff == '0)
      else $error("restart did not select quad 0");

   // The walk wraps after the final quad
   assert property (@(posedge clock) disable iff (reset)
      req_xfer && quad_is_last |=> count_ff == '0)
      else $error("counter did not wrap after final quad");

   // A quad flagged last is the level's final quad
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_last_ff |-> s1_quad_ff == last_quad)
      else $error("last flag on a quad that is not final");

   // Requests stall only behind a held counter stage
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && out_valid_ff && rsp_stall)
      else $error("request stalled with room downstream");

endmodule
